// File: sv/scflc_pkg.sv
// Shared types, field widths and defaults for the size class free list cache.
`default_nettype none
package scflc_pkg;

	localparam int OP_W   = 2;
	localparam int SIZE_W = 24;
	localparam int ADDR_W = 32;
	localparam int ACT_W  = 3;

	localparam int DEF_NUM_CLASSES       = 4;
	localparam int DEF_ENTRIES_PER_CLASS = 16;
	localparam int DEF_CLASS_STEP        = 32;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_DRAIN = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_CACHED     = 3'd0,
		ACT_HEAP_ALLOC = 3'd1,
		ACT_RELEASE    = 3'd2,
		ACT_KEPT       = 3'd3,
		ACT_EMPTY      = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_WAIT
	} state_t;

endpackage
`default_nettype wire

// File: sv/scflc_ram.sv
// Single port block store of cached addresses with a registered read.
`default_nettype none
module scflc_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic          re,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output      logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// File: sv/scflc_class.sv
// Maps a byte size to its size class and flags sizes beyond the largest class.
`default_nettype none
module scflc_class #(
	parameter int NUM_CLASSES = 4,
	parameter int CLASS_STEP  = 32,
	parameter int CW          = 2
) (
	input  wire logic [scflc_pkg::SIZE_W-1:0] size,
	output      logic [CW-1:0]                cls,
	output      logic                         oversize
);
	import scflc_pkg::*;

	localparam logic [SIZE_W-1:0] LARGE_LIMIT = SIZE_W'(NUM_CLASSES * CLASS_STEP);

	// Thresholds rise with the class, so the highest one exceeded wins.
	always_comb begin
		cls = '0;
		for (int c = 0; c < NUM_CLASSES - 1; c++) begin
			if (size > SIZE_W'((c + 1) * CLASS_STEP)) begin
				cls = CW'(c + 1);
			end
		end
	end

	assign oversize = size > LARGE_LIMIT;

endmodule
`default_nettype wire

// File: sv/size_class_free_list_cache.sv
// Top level: per size class LIFO cache of freed blocks in front of a heap.
// Each result is registered; a cache hit first passes the store output register and rd_s1.
// Throughput: one item per cycle while busy is low; cache hits and drains set busy.
// Drain: pops each cached block top first, steps over empty classes, then passes a wait state.
// Reset clears the per class fill counts at once; the address store itself is not cleared.
// Results cannot be held off: each appears for one cycle with result_valid high.
`default_nettype none
module size_class_free_list_cache #(
	parameter int NUM_CLASSES       = scflc_pkg::DEF_NUM_CLASSES,
	parameter int ENTRIES_PER_CLASS = scflc_pkg::DEF_ENTRIES_PER_CLASS,
	parameter int CLASS_STEP        = scflc_pkg::DEF_CLASS_STEP
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output      logic                         busy,
	input  wire logic [scflc_pkg::OP_W-1:0]   operation,
	input  wire logic [scflc_pkg::SIZE_W-1:0] req_size,
	input  wire logic [scflc_pkg::ADDR_W-1:0] block_address,
	output      logic                         result_valid,
	output      logic [scflc_pkg::ACT_W-1:0]  action,
	output      logic [scflc_pkg::ADDR_W-1:0] out_address,
	output      logic [scflc_pkg::SIZE_W-1:0] out_size,
	output      logic                         last
);
	import scflc_pkg::*;

	// The store holds ENTRIES_PER_CLASS slots per class, class after class.
	localparam int DEPTH = NUM_CLASSES * ENTRIES_PER_CLASS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int FW    = $clog2(ENTRIES_PER_CLASS + 1);
	localparam logic [FW-1:0]     FILL_MAX = FW'(ENTRIES_PER_CLASS);
	localparam logic [SIZE_W-1:0] STEP_SZ  = SIZE_W'(CLASS_STEP);

	// Block size of a class: (class + 1) * CLASS_STEP.
	function automatic logic [SIZE_W-1:0] class_bytes(input logic [CW-1:0] c);
		return SIZE_W'(c) * STEP_SZ + STEP_SZ;
	endfunction

	state_t state_q, state_d;

	logic [FW-1:0] fill_q [NUM_CLASSES];
	logic [CW-1:0] dcls_q;

	// Read pipeline: a store read lands in the store output register and rd_s1, then in the result register.
	logic          rd_s1;
	logic [CW-1:0] cls_s1;
	logic          last_s1;
	action_t       act_s1;

	logic [CW-1:0] in_cls;
	logic          in_large;
	logic          accept;

	logic [CW-1:0] sel_cls;
	logic [FW-1:0] fill_sel;
	logic [NUM_CLASSES-1:0] nz;
	logic          any_nz;
	logic          above;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [ADDR_W-1:0] mem_rdata;

	logic          fill_inc;
	logic          fill_dec;
	logic          dcls_clr;
	logic          dcls_step;
	logic          rd_issue;
	logic          rd_last;
	action_t       rd_act;

	logic              imm_valid;
	action_t           imm_act;
	logic [ADDR_W-1:0] imm_addr;
	logic [SIZE_W-1:0] imm_size;

	scflc_class #(
		.NUM_CLASSES (NUM_CLASSES),
		.CLASS_STEP  (CLASS_STEP),
		.CW          (CW)
	) u_class (
		.size     (req_size),
		.cls      (in_cls),
		.oversize (in_large)
	);

	scflc_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (block_address),
		.rdata (mem_rdata)
	);

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	// While draining, the walk class picks the counter; otherwise the incoming size does.
	assign sel_cls  = (state_q == ST_DRAIN) ? dcls_q : in_cls;
	assign fill_sel = fill_q[sel_cls];

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			nz[c] = fill_q[c] != '0;
		end
	end

	assign any_nz = |nz;

	// Tells whether any class after the one being drained still holds blocks.
	always_comb begin
		above = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (nz[c] && (c > int'(dcls_q))) begin
				above = 1'b1;
			end
		end
	end

	// A push writes the slot at the fill count; a pop reads the one just below it.
	assign mem_addr = AW'(sel_cls) * AW'(ENTRIES_PER_CLASS) + AW'(fill_sel) - AW'(!fill_inc);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		fill_inc  = 1'b0;
		fill_dec  = 1'b0;
		dcls_clr  = 1'b0;
		dcls_step = 1'b0;
		rd_issue  = 1'b0;
		rd_last   = 1'b0;
		rd_act    = ACT_CACHED;
		imm_valid = 1'b0;
		imm_act   = ACT_EMPTY;
		imm_addr  = '0;
		imm_size  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(operation))
						OP_ALLOC: begin
							if (in_large) begin
								imm_valid = 1'b1;
								imm_act   = ACT_HEAP_ALLOC;
								imm_size  = req_size;
							end else if (fill_sel == '0) begin
								imm_valid = 1'b1;
								imm_act   = ACT_HEAP_ALLOC;
								imm_size  = class_bytes(in_cls);
							end else begin
								mem_re   = 1'b1;
								fill_dec = 1'b1;
								rd_issue = 1'b1;
								rd_last  = 1'b1;
								rd_act   = ACT_CACHED;
								state_d  = ST_WAIT;
							end
						end
						OP_FREE: begin
							if (in_large) begin
								imm_valid = 1'b1;
								imm_act   = ACT_RELEASE;
								imm_addr  = block_address;
								imm_size  = req_size;
							end else if (fill_sel == FILL_MAX) begin
								imm_valid = 1'b1;
								imm_act   = ACT_RELEASE;
								imm_addr  = block_address;
								imm_size  = class_bytes(in_cls);
							end else begin
								mem_we    = 1'b1;
								fill_inc  = 1'b1;
								imm_valid = 1'b1;
								imm_act   = ACT_KEPT;
								imm_size  = class_bytes(in_cls);
							end
						end
						OP_DRAIN: begin
							if (!any_nz) begin
								imm_valid = 1'b1;
								imm_act   = ACT_EMPTY;
							end else begin
								dcls_clr = 1'b1;
								state_d  = ST_DRAIN;
							end
						end
						OP_RSVD: begin
						end
					endcase
				end
			end
			ST_DRAIN: begin
				// Pop one block per cycle, top of stack first; step over an empty class without a read.
				if (fill_sel != '0) begin
					mem_re   = 1'b1;
					fill_dec = 1'b1;
					rd_issue = 1'b1;
					rd_act   = ACT_RELEASE;
					rd_last  = (fill_sel == FW'(1)) && !above;
					if (rd_last) begin
						state_d = ST_WAIT;
					end else if (fill_sel == FW'(1)) begin
						dcls_step = 1'b1;
					end
				end else begin
					dcls_step = 1'b1;
				end
			end
			ST_WAIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				fill_q[c] <= '0;
			end
			dcls_q <= '0;
		end else begin
			if (fill_dec) begin
				fill_q[sel_cls] <= fill_sel - FW'(1);
			end else if (fill_inc) begin
				fill_q[sel_cls] <= fill_sel + FW'(1);
			end
			if (dcls_clr) begin
				dcls_q <= '0;
			end else if (dcls_step) begin
				dcls_q <= dcls_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			cls_s1  <= sel_cls;
			last_s1 <= rd_last;
			act_s1  <= rd_act;
		end
	end

	// Result register: the store read path and the direct path never land in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= rd_s1 || imm_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			action      <= act_s1;
			out_address <= mem_rdata;
			out_size    <= class_bytes(cls_s1);
			last        <= last_s1;
		end else if (imm_valid) begin
			action      <= imm_act;
			out_address <= imm_addr;
			out_size    <= imm_size;
			last        <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: sv/scflc_chk.sv
// Port level checker for the size class free list cache, bound to the top level.
`default_nettype none
module scflc_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [scflc_pkg::OP_W-1:0]   operation,
	input wire logic                         result_valid,
	input wire logic [scflc_pkg::ACT_W-1:0]  action,
	input wire logic [scflc_pkg::ADDR_W-1:0] out_address,
	input wire logic [scflc_pkg::SIZE_W-1:0] out_size,
	input wire logic                         last
);
	import scflc_pkg::*;

	// Allocate and free items give exactly one result, so it is always the final one.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (action == ACT_CACHED || action == ACT_HEAP_ALLOC ||
		action == ACT_KEPT) |-> last)
		else $error("single result item without last");

	// An empty drain reports nothing but the marker.
	a_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == ACT_EMPTY |->
		last && out_address == '0 && out_size == '0)
		else $error("empty drain result carries data");

	// A block kept in the cache returns no address.
	a_kept_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && action == ACT_KEPT |-> out_address == '0)
		else $error("kept result carries an address");

	// More results of the same item follow, so no new item may be taken meanwhile.
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("not busy while a drain still has results to give");

	// The unused operation code produces no result.
	a_rsvd_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_RSVD |=> !result_valid)
		else $error("result after an unused operation code");

endmodule

bind size_class_free_list_cache scflc_chk u_scflc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.operation    (operation),
	.result_valid (result_valid),
	.action       (action),
	.out_address  (out_address),
	.out_size     (out_size),
	.last         (last)
);
`default_nettype wire

// File: sim/tb_size_class_free_list_cache.sv
// Self-checking testbench for the size class free list cache.
`timescale 1ns / 1ps
module tb_size_class_free_list_cache;
	import scflc_pkg::*;

	// The block is built with its default sizes. The mirror below uses the same values.
	localparam int NUM_CLASSES       = DEF_NUM_CLASSES;
	localparam int ENTRIES_PER_CLASS = DEF_ENTRIES_PER_CLASS;
	localparam int CLASS_STEP        = DEF_CLASS_STEP;
	localparam int LARGE_LIMIT       = NUM_CLASSES * CLASS_STEP;

	// A drain emits one result per cached block and also steps over each empty class.
	// The settle time at the end covers the longest drain with margin.
	localparam int SETTLE_CYCLES = 2 * (NUM_CLASSES * ENTRIES_PER_CLASS + NUM_CLASSES) + 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 110;
	localparam int PHASE_ITEMS   = 24;
	localparam int MAX_REPORTS   = 10;

	// One result as the block presents it on its output ports.
	typedef struct {
		action_t                act;
		logic [ADDR_W-1:0]      addr;
		logic [SIZE_W-1:0]      size;
		logic                   last;
	} cache_result_t;

	// The random part runs in phases. Each phase favors one kind of traffic, so the
	// stacks fill up, overflow and empty again many times during the run.
	typedef enum {
		PH_FILL,
		PH_MIXED,
		PH_EMPTYING
	} traffic_phase_t;

	// The mirror keeps its own copy of every class stack. For each accepted item it
	// appends the results that the block must produce to due_results. Each result
	// that the block produces is then checked against the oldest entry there.
	class free_list_mirror;
		logic [ADDR_W-1:0] mirror_blocks [NUM_CLASSES][ENTRIES_PER_CLASS];
		int unsigned       mirror_fill [NUM_CLASSES];
		cache_result_t     due_results [$];
		int                errors;
		int                reports;

		function new();
			foreach (mirror_fill[c]) mirror_fill[c] = 0;
			errors  = 0;
			reports = 0;
		endfunction

		function int unsigned class_of(logic [SIZE_W-1:0] size);
			return (size == 0) ? 0 : (int'(size) - 1) / CLASS_STEP;
		endfunction

		function logic [SIZE_W-1:0] class_bytes(int unsigned cls);
			return SIZE_W'((cls + 1) * CLASS_STEP);
		endfunction

		// Appends one result to the tail of the due list.
		function void add_due(cache_result_t r);
			due_results.insert(due_results.size(), r);
		endfunction

		function void accept_item(op_t op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
			int unsigned cls;
			int          released;
			released = 0;
			case (op)
				OP_ALLOC: begin
					if (size > LARGE_LIMIT) begin
						add_due('{ACT_HEAP_ALLOC, '0, size, 1'b1});
					end else begin
						cls = class_of(size);
						if (mirror_fill[cls] == 0) begin
							add_due('{ACT_HEAP_ALLOC, '0, class_bytes(cls), 1'b1});
						end else begin
							mirror_fill[cls]--;
							add_due('{ACT_CACHED,
								mirror_blocks[cls][mirror_fill[cls]], class_bytes(cls), 1'b1});
						end
					end
				end
				OP_FREE: begin
					if (size > LARGE_LIMIT) begin
						add_due('{ACT_RELEASE, addr, size, 1'b1});
					end else begin
						cls = class_of(size);
						if (mirror_fill[cls] >= ENTRIES_PER_CLASS) begin
							add_due('{ACT_RELEASE, addr, class_bytes(cls), 1'b1});
						end else begin
							mirror_blocks[cls][mirror_fill[cls]] = addr;
							mirror_fill[cls]++;
							add_due('{ACT_KEPT, '0, class_bytes(cls), 1'b1});
						end
					end
				end
				OP_DRAIN: begin
					for (int c = 0; c < NUM_CLASSES; c++) begin
						while (mirror_fill[c] > 0) begin
							mirror_fill[c]--;
							add_due('{ACT_RELEASE,
								mirror_blocks[c][mirror_fill[c]], class_bytes(c), 1'b0});
							released++;
						end
					end
					if (released == 0)
						add_due('{ACT_EMPTY, '0, '0, 1'b1});
					else
						due_results[due_results.size() - 1].last = 1'b1;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(cache_result_t got);
			cache_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("unexpected result: action=%0d addr=%h size=%h last=%0d",
						got.act, got.addr, got.size, got.last);
				reports++;
				return;
			end
			want = due_results.pop_front();
			if (got.act !== want.act || got.addr !== want.addr ||
				got.size !== want.size || got.last !== want.last) begin
				errors++;
				if (reports < MAX_REPORTS)
					$display("mismatch: expected action=%0d addr=%h size=%h last=%0d, %s",
						want.act, want.addr, want.size, want.last,
						$sformatf("got action=%0d addr=%h size=%h last=%0d",
							got.act, got.addr, got.size, got.last));
				reports++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [OP_W-1:0]   operation;
	logic [SIZE_W-1:0] req_size;
	logic [ADDR_W-1:0] block_address;
	logic              result_valid;
	logic [ACT_W-1:0]  action;
	logic [ADDR_W-1:0] out_address;
	logic [SIZE_W-1:0] out_size;
	logic              last;

	free_list_mirror mirror;
	int              cycle_count;
	bit              no_idle;

	size_class_free_list_cache u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.req_size      (req_size),
		.block_address (block_address),
		.result_valid  (result_valid),
		.action        (action),
		.out_address   (out_address),
		.out_size      (out_size),
		.last          (last)
	);

	// The clock starts low so that the first falling edge comes after the first rise.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog ends a run that hangs, for example when a result never shows up.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Results are sampled at the rising edge that ends their cycle. The receiver
	// cannot stall the block, so every strobe is checked as it comes.
	always @(posedge clk) begin
		if (arst_n && result_valid)
			mirror.check_result('{action_t'(action), out_address, out_size, last});
	end

	// The sender idles for a randomly drawn gap before each item, except in
	// stretches where idling is switched off and items follow back to back.
	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	// Presents one item from a falling edge on and holds it until the block takes it.
	// The item counts as accepted at the first rising edge with busy low. The task
	// returns at the falling edge after that, so a gap of zero keeps start high.
	task automatic send_item(op_t op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr,
		int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start         = 1'b1;
		operation     = op;
		req_size      = size;
		block_address = addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		mirror.accept_item(op, size, addr);
		@(negedge clk);
	endtask

	// Draws a size that lands in the given class. Class 0 also takes size zero.
	function automatic logic [SIZE_W-1:0] size_in_class(int cls);
		if (cls == 0)
			return SIZE_W'($urandom_range(0, CLASS_STEP));
		return SIZE_W'($urandom_range(cls * CLASS_STEP + 1, (cls + 1) * CLASS_STEP));
	endfunction

	initial begin
		traffic_phase_t    phase;
		int                phase_left;
		int                focus;
		int                counted;
		int                pick;
		int                cls;
		op_t               op;
		logic [SIZE_W-1:0] size;

		mirror        = new();
		no_idle       = 1'b0;
		start         = 1'b0;
		operation     = OP_ALLOC;
		req_size      = '0;
		block_address = '0;
		arst_n        = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items. The run opens with a drain of an empty cache, then hits
		// both ends of the size range and the edge of the large size threshold.
		send_item(OP_DRAIN, 24'd0, 32'd0, draw_gap());
		send_item(OP_ALLOC, 24'd0, 32'd0, draw_gap());
		send_item(OP_ALLOC, SIZE_W'(LARGE_LIMIT), 32'd0, draw_gap());
		send_item(OP_ALLOC, SIZE_W'(LARGE_LIMIT + 1), 32'd0, draw_gap());
		send_item(OP_ALLOC, 24'hFFFFFF, 32'hFFFFFFFF, draw_gap());
		// Frees fill a few stacks. A size of 50 does not match its class block size,
		// so the block must come back later with the class size of 64.
		send_item(OP_FREE, 24'd0, 32'd0, draw_gap());
		send_item(OP_FREE, SIZE_W'(CLASS_STEP + 1), 32'hFFFFFFFF, draw_gap());
		send_item(OP_FREE, 24'd50, $urandom(), draw_gap());
		send_item(OP_FREE, SIZE_W'(LARGE_LIMIT), $urandom(), draw_gap());
		// Large frees bypass the cache and go straight back to the heap.
		send_item(OP_FREE, SIZE_W'(LARGE_LIMIT + 1), $urandom(), draw_gap());
		send_item(OP_FREE, 24'hFFFFFF, 32'hFFFFFFFF, draw_gap());
		// The unused operation code must be taken without any result.
		send_item(OP_RSVD, 24'hFFFFFF, 32'hFFFFFFFF, draw_gap());
		// Pops return the most recent block of each class first.
		send_item(OP_ALLOC, SIZE_W'(2 * CLASS_STEP), 32'd0, draw_gap());
		send_item(OP_ALLOC, 24'd1, 32'd0, draw_gap());
		send_item(OP_FREE, SIZE_W'(2 * CLASS_STEP + 1), $urandom(), draw_gap());
		// This drain releases blocks from several classes and marks only the final one.
		send_item(OP_DRAIN, 24'd0, 32'd0, draw_gap());
		send_item(OP_DRAIN, SIZE_W'($urandom()), $urandom(), draw_gap());

		// Random items in phases. Fill phases push mostly into one class so that the
		// stack overflows and blocks are released. Other phases pop and drain.
		phase_left = 0;
		counted    = 0;
		phase      = PH_FILL;
		focus      = 0;
		while (counted < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase      = traffic_phase_t'($urandom_range(0, 2));
				focus      = $urandom_range(0, NUM_CLASSES - 1);
				no_idle    = ($urandom_range(0, 3) == 0);
				phase_left = PHASE_ITEMS;
			end
			pick = $urandom_range(0, 99);
			case (phase)
				PH_FILL:  op = (pick < 88) ? OP_FREE : (pick < 97) ? OP_ALLOC : OP_RSVD;
				PH_MIXED: op = (pick < 45) ? OP_FREE : (pick < 85) ? OP_ALLOC :
					(pick < 95) ? OP_DRAIN : OP_RSVD;
				default:  op = (pick < 20) ? OP_FREE : (pick < 88) ? OP_ALLOC :
					(pick < 96) ? OP_DRAIN : OP_RSVD;
			endcase
			// One size in ten is large and drawn from above the large limit up to the top
			// of the field, which also makes every bit of the size field toggle.
			if ($urandom_range(0, 9) == 0) begin
				size = SIZE_W'($urandom_range(LARGE_LIMIT + 1, 24'hFFFFFF));
			end else begin
				cls  = ($urandom_range(0, 4) != 0) ? focus : $urandom_range(0, NUM_CLASSES - 1);
				size = size_in_class(cls);
			end
			send_item(op, size, $urandom(), draw_gap());
			if (op != OP_RSVD) begin
				counted++;
				phase_left--;
			end
		end
		// A final drain empties whatever the random part left behind.
		send_item(OP_DRAIN, 24'd0, 32'd0, draw_gap());
		start = 1'b0;

		// Wait for every due result, then a while longer to catch stray strobes.
		while (mirror.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
